/* rtl/core/hktu_pkg.sv */
package hktu_pkg;

  localparam int PLY_COUNT = 64;
  localparam int PLY_AW = $clog2(PLY_COUNT);

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW = $clog2(HIST_DEPTH);

  localparam int MOVE_W = 16;
  localparam int SQ_W = 6;
  localparam int PLY_W = 6;
  localparam int DEPTH_W = 7;
  localparam int CFG_W = 15;
  localparam int CFG_IDX_W = 1;
  localparam int SCORE_W = 16;

  localparam int HIST_LIMIT = 16384;
  localparam int HIST_SHIFT = 14;
  localparam int BONUS_PER_DEPTH_RST = 300;
  localparam int BONUS_CAP_RST = 2100;
  localparam int FULL_UPDATE_DEPTH = 2;

  typedef enum logic {
    OP_CUTOFF  = 1'b0,
    OP_PENALTY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BONUS_PER_DEPTH = 1'b0,
    REG_BONUS_CAP       = 1'b1
  } reg_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

/* rtl/core/hktu_ctrl.sv */
module hktu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  hktu_pkg::sts_t    sts_i,
  output hktu_pkg::cmd_t    cmd_o
);
  import hktu_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd.clear = (state_q == S_CLEAR);
    cmd.load  = (state_q == S_IDLE) && in_valid_i;
    cmd.exec  = (state_q == S_EXEC) && !(out_valid_q && out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.load, cmd.exec}))
    else $error("Controller issued more than one command.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !(out_valid_q && out_stall_i))
    else $error("Result register loaded while a stalled beat waits.");

  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (state_q == S_EXEC) && in_stall_o)
    else $error("Accepted item did not enter execution.");

  a_no_load_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !cmd.load && in_stall_o)
    else $error("Item accepted during the history clearing pass.");
`endif

endmodule

/* rtl/core/hktu_dp.sv */
module hktu_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hktu_pkg::cmd_t                        cmd_i,
  output hktu_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [hktu_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hktu_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  op_i,
  input  logic [hktu_pkg::MOVE_W-1:0]           move_code_i,
  input  logic [hktu_pkg::SQ_W-1:0]             from_square_i,
  input  logic [hktu_pkg::SQ_W-1:0]             to_square_i,
  input  logic [hktu_pkg::PLY_W-1:0]            ply_i,
  input  logic [hktu_pkg::DEPTH_W-1:0]          depth_i,
  output logic signed [hktu_pkg::SCORE_W-1:0]   history_score_o,
  output logic                                  applied_o,
  output logic [hktu_pkg::MOVE_W-1:0]           killer_first_o,
  output logic [hktu_pkg::MOVE_W-1:0]           killer_second_o
);
  import hktu_pkg::*;

  localparam int PROD_W = CFG_W + DEPTH_W;
  localparam int GPROD_W = 2 * SCORE_W;
  localparam int SUM_W = SCORE_W + 2;
  localparam int ROW_W = 2 * MOVE_W;

  logic [CFG_W-1:0] bpd_q;
  logic [CFG_W-1:0] cap_q;

  logic signed [SCORE_W-1:0] hist_mem [HIST_DEPTH];
  logic [ROW_W-1:0]          kill_mem [PLY_COUNT];
  logic [PLY_COUNT-1:0]      kvalid_q;
  logic [HIST_AW-1:0]        clr_cnt_q;

  logic [MOVE_W-1:0] best_q;
  logic [CFG_W-1:0]  cur_bonus_q;

  op_e                       op_q;
  logic [MOVE_W-1:0]         code_q;
  logic [HIST_AW-1:0]        idx_q;
  logic [PLY_AW-1:0]         ply_idx_q;
  logic                      ply_ok_q;
  logic                      depth_gt_q;
  logic [CFG_W-1:0]          bonus_new_q;
  logic signed [SCORE_W-1:0] hist_rd_q;
  logic [ROW_W-1:0]          krow_q;
  logic                      khit_q;

  logic signed [SCORE_W-1:0] score_q;
  logic                      applied_q;
  logic [MOVE_W-1:0]         kfirst_out_q;
  logic [MOVE_W-1:0]         ksecond_out_q;

  logic [PLY_AW-1:0]  ply_idx;
  logic [HIST_AW-1:0] rd_idx;
  logic [DEPTH_W-1:0] depth_m1;
  logic [PROD_W-1:0]  bonus_prod;
  logic [PROD_W-1:0]  bonus_capped;
  logic [CFG_W-1:0]   bonus_new;

  always_comb begin
    ply_idx  = PLY_AW'(ply_i);
    rd_idx   = {from_square_i, to_square_i};
    depth_m1 = depth_i - DEPTH_W'(1);
    if (depth_i == '0) begin
      bonus_prod = '0;
    end else begin
      bonus_prod = PROD_W'(bpd_q) * PROD_W'(depth_m1);
    end
    if (bonus_prod > PROD_W'(cap_q)) begin
      bonus_capped = PROD_W'(cap_q);
    end else begin
      bonus_capped = bonus_prod;
    end
    if (bonus_capped > PROD_W'(HIST_LIMIT)) begin
      bonus_new = CFG_W'(HIST_LIMIT);
    end else begin
      bonus_new = CFG_W'(bonus_capped);
    end
  end

  logic                      is_cutoff;
  logic [CFG_W-1:0]          bsel;
  logic                      apply;
  logic signed [SCORE_W-1:0] bsel_s;
  logic signed [GPROD_W-1:0] gprod;
  logic signed [GPROD_W-1:0] gprod_adj;
  logic signed [SUM_W-1:0]   quo;
  logic signed [SUM_W-1:0]   gsum;
  logic signed [SCORE_W-1:0] gsat;
  logic [MOVE_W-1:0]         kfirst;
  logic [MOVE_W-1:0]         ksecond;
  logic [ROW_W-1:0]          krow_new;

  always_comb begin
    is_cutoff = (op_q == OP_CUTOFF);
    bsel      = is_cutoff ? bonus_new_q : cur_bonus_q;
    apply     = is_cutoff ? depth_gt_q : (code_q != best_q);
    bsel_s    = $signed({1'b0, bsel});
    gprod     = GPROD_W'(hist_rd_q) * GPROD_W'(bsel_s);
    // Bias negative products so the shift truncates toward zero.
    gprod_adj = gprod + (gprod[GPROD_W-1] ?
                GPROD_W'((1 << HIST_SHIFT) - 1) : GPROD_W'(0));
    quo       = SUM_W'(gprod_adj >>> HIST_SHIFT);
    if (is_cutoff) begin
      gsum = SUM_W'(hist_rd_q) + SUM_W'(bsel_s) - quo;
    end else begin
      gsum = SUM_W'(hist_rd_q) - SUM_W'(bsel_s) - quo;
    end
    if (gsum > SUM_W'(HIST_LIMIT)) begin
      gsat = SCORE_W'(HIST_LIMIT);
    end else if (gsum < -SUM_W'(HIST_LIMIT)) begin
      gsat = -SCORE_W'(HIST_LIMIT);
    end else begin
      gsat = SCORE_W'(gsum);
    end

    kfirst  = khit_q ? krow_q[ROW_W-1:MOVE_W] : '0;
    ksecond = khit_q ? krow_q[MOVE_W-1:0] : '0;
    if (is_cutoff && ply_ok_q && (kfirst != code_q)) begin
      krow_new = {code_q, kfirst};
    end else begin
      krow_new = {kfirst, ksecond};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpd_q <= CFG_W'(BONUS_PER_DEPTH_RST);
      cap_q <= CFG_W'(BONUS_CAP_RST);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_BONUS_PER_DEPTH: bpd_q <= cfg_data_i;
        REG_BONUS_CAP:       cap_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      kvalid_q    <= '0;
      best_q      <= '0;
      cur_bonus_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + HIST_AW'(1);
      end
      if (cmd_i.exec && is_cutoff) begin
        best_q      <= code_q;
        cur_bonus_q <= bonus_new_q;
        if (ply_ok_q) begin
          kvalid_q[ply_idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      hist_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.exec && apply) begin
      hist_mem[idx_q] <= gsat;
    end
    if (cmd_i.exec && is_cutoff && ply_ok_q) begin
      kill_mem[ply_idx_q] <= krow_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= op_e'(op_i);
      code_q      <= move_code_i;
      idx_q       <= rd_idx;
      ply_idx_q   <= ply_idx;
      ply_ok_q    <= (32'(ply_i) < PLY_COUNT);
      depth_gt_q  <= (depth_i > DEPTH_W'(FULL_UPDATE_DEPTH));
      bonus_new_q <= bonus_new;
      hist_rd_q   <= hist_mem[rd_idx];
      krow_q      <= kill_mem[ply_idx];
      khit_q      <= kvalid_q[ply_idx];
    end
    if (cmd_i.exec) begin
      score_q       <= apply ? gsat : hist_rd_q;
      applied_q     <= apply;
      kfirst_out_q  <= ply_ok_q ? krow_new[ROW_W-1:MOVE_W] : '0;
      ksecond_out_q <= ply_ok_q ? krow_new[MOVE_W-1:0] : '0;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == '1);
  assign history_score_o  = score_q;
  assign applied_o        = applied_q;
  assign killer_first_o   = kfirst_out_q;
  assign killer_second_o  = ksecond_out_q;

endmodule

/* rtl/core/history_and_killer_table_update.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   op, move_code, from/to_square, ply, depth
// out       output     out_valid_o / out_stall_i history_score, applied, killer_first/second
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item is first accepted, with its history entry and killer row read, and then runs the
// gravity update and writes the updated entries back; the next item is accepted only after that.
// After reset the history memory is cleared one entry a cycle; no beat is accepted in that time,
// while configuration writes are always taken.
// A stalled result holds in the output register; the next item is still accepted and
// read, and waits to execute until the output register is free.
module history_and_killer_table_update (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic [hktu_pkg::MOVE_W-1:0]           move_code_i,
  input  logic [hktu_pkg::SQ_W-1:0]             from_square_i,
  input  logic [hktu_pkg::SQ_W-1:0]             to_square_i,
  input  logic [hktu_pkg::PLY_W-1:0]            ply_i,
  input  logic [hktu_pkg::DEPTH_W-1:0]          depth_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hktu_pkg::SCORE_W-1:0]   history_score_o,
  output logic                                  applied_o,
  output logic [hktu_pkg::MOVE_W-1:0]           killer_first_o,
  output logic [hktu_pkg::MOVE_W-1:0]           killer_second_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hktu_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hktu_pkg::CFG_W-1:0]            cfg_data_i
);
  import hktu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  hktu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hktu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .move_code_i     (move_code_i),
    .from_square_i   (from_square_i),
    .to_square_i     (to_square_i),
    .ply_i           (ply_i),
    .depth_i         (depth_i),
    .history_score_o (history_score_o),
    .applied_o       (applied_o),
    .killer_first_o  (killer_first_o),
    .killer_second_o (killer_second_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hktu_pkg::*;

  typedef struct {
    op_e                op;
    logic [MOVE_W-1:0]  code;
    logic [SQ_W-1:0]    from_sq;
    logic [SQ_W-1:0]    to_sq;
    logic [PLY_W-1:0]   ply;
    logic [DEPTH_W-1:0] depth;
  } move_item_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      applied;
    logic [MOVE_W-1:0]         killer_first;
    logic [MOVE_W-1:0]         killer_second;
  } table_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      op = 1'b0;
  logic [MOVE_W-1:0]         move_code = '0;
  logic [SQ_W-1:0]           from_square = '0;
  logic [SQ_W-1:0]           to_square = '0;
  logic [PLY_W-1:0]          ply = '0;
  logic [DEPTH_W-1:0]        depth = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SCORE_W-1:0] history_score;
  logic                      applied;
  logic [MOVE_W-1:0]         killer_first;
  logic [MOVE_W-1:0]         killer_second;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  reg_e                      cfg_index = REG_BONUS_PER_DEPTH;
  logic [CFG_W-1:0]          cfg_data = '0;

  int history_tbl [HIST_DEPTH] = '{default: 0};
  logic [MOVE_W-1:0] killer_tbl [2][PLY_COUNT] = '{default: '{default: '0}};
  logic [MOVE_W-1:0] last_best = '0;
  int last_bonus = 0;
  int bonus_per_depth = BONUS_PER_DEPTH_RST;
  int bonus_cap = BONUS_CAP_RST;

  table_result_t expected_updates [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 70;
  int hold_request = 0;
  int hold_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int n_cutoffs = 0;
  int n_penalties = 0;
  int n_skipped = 0;
  int n_writes = 0;
  int n_reg_writes = 0;
  int n_checked = 0;

  history_and_killer_table_update dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .move_code_i     (move_code),
    .from_square_i   (from_square),
    .to_square_i     (to_square),
    .ply_i           (ply),
    .depth_i         (depth),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .history_score_o (history_score),
    .applied_o       (applied),
    .killer_first_o  (killer_first),
    .killer_second_o (killer_second),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gravity(int entry, int bonus, bit reward);
    int r;
    r = (reward ? entry + bonus : entry - bonus) - (entry * bonus) / HIST_LIMIT;
    if (r > HIST_LIMIT) r = HIST_LIMIT;
    else if (r < -HIST_LIMIT) r = -HIST_LIMIT;
    return r;
  endfunction

  function automatic table_result_t apply_table_update(move_item_t it);
    table_result_t r;
    logic [HIST_AW-1:0] idx;
    int b;
    bit ply_ok;
    idx = {it.from_sq, it.to_sq};
    ply_ok = int'(it.ply) < PLY_COUNT;
    r.applied = 1'b0;
    if (it.op == OP_CUTOFF) begin
      n_cutoffs++;
      if (ply_ok && killer_tbl[0][it.ply] != it.code) begin
        killer_tbl[1][it.ply] = killer_tbl[0][it.ply];
        killer_tbl[0][it.ply] = it.code;
      end
      b = (it.depth == 0) ? 0 : bonus_per_depth * (int'(it.depth) - 1);
      if (b > bonus_cap) b = bonus_cap;
      if (b > HIST_LIMIT) b = HIST_LIMIT;
      last_best = it.code;
      last_bonus = b;
      if (int'(it.depth) > FULL_UPDATE_DEPTH) begin
        history_tbl[idx] = gravity(history_tbl[idx], b, 1'b1);
        r.applied = 1'b1;
      end
    end else begin
      n_penalties++;
      if (it.code != last_best) begin
        history_tbl[idx] = gravity(history_tbl[idx], last_bonus, 1'b0);
        r.applied = 1'b1;
      end else begin
        n_skipped++;
      end
    end
    if (r.applied) n_writes++;
    r.score = SCORE_W'(history_tbl[idx]);
    r.killer_first = ply_ok ? killer_tbl[0][it.ply] : '0;
    r.killer_second = ply_ok ? killer_tbl[1][it.ply] : '0;
    return r;
  endfunction

  function automatic move_item_t make_move(op_e o, int code, int from_sq, int to_sq,
                                           int ply_sel, int depth_sel);
    move_item_t m;
    m.op = o;
    m.code = MOVE_W'(code);
    m.from_sq = SQ_W'(from_sq);
    m.to_sq = SQ_W'(to_sq);
    m.ply = PLY_W'(ply_sel);
    m.depth = DEPTH_W'(depth_sel);
    return m;
  endfunction

  function automatic move_item_t random_move(op_e o, int ply_sel, int depth_sel);
    move_item_t m;
    m.op = o;
    m.ply = PLY_W'(ply_sel);
    m.depth = DEPTH_W'(depth_sel);
    if ($urandom_range(99) < 70) begin
      m.from_sq = SQ_W'($urandom_range(3));
      m.to_sq = SQ_W'($urandom_range(3));
    end else begin
      m.from_sq = SQ_W'($urandom);
      m.to_sq = SQ_W'($urandom);
    end
    if ($urandom_range(99) < 85) begin
      m.code[15:12] = ($urandom_range(99) < 75) ? 4'h0 : 4'($urandom);
      m.code[11:0] = {m.from_sq, m.to_sq};
    end else begin
      m.code = MOVE_W'($urandom);
    end
    return m;
  endfunction

  function automatic int random_ply();
    return ($urandom_range(99) < 80) ? int'($urandom_range(7)) : int'($urandom_range(63));
  endfunction

  function automatic int random_depth();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(1, 8);
    if (roll < 90) return $urandom_range(9, 30);
    return $urandom_range(1, 127);
  endfunction

  task automatic send_move(input move_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    move_code <= it.code;
    from_square <= it.from_sq;
    to_square <= it.to_sq;
    ply <= it.ply;
    depth <= it.depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_updates.push_back(apply_table_update(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_updates.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e which, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (which == REG_BONUS_PER_DEPTH) bonus_per_depth = value & 32'h7FFF;
    else bonus_cap = value & 32'h7FFF;
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic search_node();
    move_item_t best;
    move_item_t quiet;
    int node_ply;
    int node_depth;
    int n_quiet;
    node_ply = random_ply();
    node_depth = random_depth();
    best = random_move(OP_CUTOFF, node_ply, node_depth);
    send_move(best);
    n_quiet = $urandom_range(5);
    for (int i = 0; i < n_quiet; i++) begin
      quiet = random_move(OP_PENALTY, node_ply, node_depth);
      if ($urandom_range(99) < 15) quiet.code = best.code;
      send_move(quiet);
    end
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_move(random_move($urandom_range(1) ? OP_PENALTY : OP_CUTOFF,
                              $urandom_range(63), $urandom_range(1, 127)));
      end else begin
        search_node();
      end
    end
    wait_for_results();
  endtask

  task automatic test_directed_cases();
    send_move(make_move(OP_CUTOFF, 16'h0000, 0, 0, 0, 1));
    send_move(make_move(OP_CUTOFF, 16'h0041, 1, 1, 0, 2));
    send_move(make_move(OP_CUTOFF, 16'h0041, 1, 1, 0, 3));
    send_move(make_move(OP_CUTOFF, 16'hFFFF, 63, 63, 63, 127));
    send_move(make_move(OP_PENALTY, 16'hFFFF, 63, 63, 63, 5));
    send_move(make_move(OP_PENALTY, 16'h1234, 63, 63, 63, 1));
    send_move(make_move(OP_PENALTY, 16'h0000, 0, 0, 0, 127));
    send_move(make_move(OP_CUTOFF, 16'h8000, 5, 9, 5, 0));
    send_move(make_move(OP_PENALTY, 16'h0001, 5, 9, 5, 0));
    wait_for_results();
    write_reg(REG_BONUS_PER_DEPTH, HIST_LIMIT);
    write_reg(REG_BONUS_CAP, HIST_LIMIT);
    send_move(make_move(OP_CUTOFF, 16'h00C3, 3, 3, 1, 2));
    send_move(make_move(OP_CUTOFF, 16'h00C3, 3, 3, 1, 3));
    send_move(make_move(OP_CUTOFF, 16'h00C3, 3, 3, 1, 3));
    send_move(make_move(OP_PENALTY, 16'h00C4, 3, 3, 1, 3));
    send_move(make_move(OP_PENALTY, 16'h00C4, 3, 3, 1, 3));
    wait_for_results();
    write_reg(REG_BONUS_PER_DEPTH, 0);
    write_reg(REG_BONUS_CAP, 0);
    send_move(make_move(OP_CUTOFF, 16'h7FFF, 3, 3, 2, 100));
    send_move(make_move(OP_PENALTY, 16'h7FFE, 3, 3, 2, 100));
    wait_for_results();
    write_reg(REG_BONUS_PER_DEPTH, 16383);
    write_reg(REG_BONUS_CAP, 1);
    send_move(make_move(OP_CUTOFF, 16'h00C3, 3, 3, 1, 3));
    send_move(make_move(OP_PENALTY, 16'h0FFF, 63, 63, 1, 3));
    wait_for_results();
  endtask

  task automatic test_receiver_heavy_stall();
    send_idle_pct = 35;
    recv_idle_pct = 70;
    write_reg(REG_BONUS_PER_DEPTH, BONUS_PER_DEPTH_RST);
    write_reg(REG_BONUS_CAP, BONUS_CAP_RST);
    random_phase(130);
  endtask

  task automatic test_sender_heavy_idle();
    send_idle_pct = 70;
    recv_idle_pct = 35;
    write_reg(REG_BONUS_PER_DEPTH, $urandom_range(2000));
    write_reg(REG_BONUS_CAP, $urandom_range(HIST_LIMIT));
    random_phase(130);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BONUS_PER_DEPTH, HIST_LIMIT);
    write_reg(REG_BONUS_CAP, 16383);
    random_phase(130);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BONUS_PER_DEPTH, 700);
    write_reg(REG_BONUS_CAP, 5000);
    hold_request = 300;
    random_phase(20);
    random_phase(10);
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        $error("result beat with no expected result waiting");
        error_count++;
      end else begin
        exp_r = expected_updates.pop_front();
        n_checked++;
        if (history_score !== exp_r.score) begin
          $error("history_score: expected %0d, actual %0d", exp_r.score, history_score);
          error_count++;
        end
        if (applied !== exp_r.applied) begin
          $error("applied: expected %0d, actual %0d", exp_r.applied, applied);
          error_count++;
        end
        if (killer_first !== exp_r.killer_first) begin
          $error("killer_first: expected %h, actual %h", exp_r.killer_first, killer_first);
          error_count++;
        end
        if (killer_second !== exp_r.killer_second) begin
          $error("killer_second: expected %h, actual %h", exp_r.killer_second,
                 killer_second);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_receiver_heavy_stall();
    test_sender_heavy_idle();
    test_full_rate();
    test_output_hold_off();
    repeat (20) @(negedge clk);
    $display("Sent %0d moves: %0d cutoffs, %0d penalties, %0d penalties skipped as best move.",
             items_sent, n_cutoffs, n_penalties, n_skipped);
    $display("Checked %0d result beats with %0d history writes over %0d register writes.",
             n_checked, n_writes, n_reg_writes);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
